// File: rtl/quaternion_vector_rotate_defines.svh
// Assertion macros used by the quaternion rotation top level.
// Clock aclk and active-low reset aresetn are taken from the including module.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QVR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
// No dependencies.
package qvr_pkg;

    localparam int QUAT_BITS = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } cfg_reg_t;

    // Quaternion held in the configuration registers, fixed point signed.
    typedef struct packed {
        logic signed [QUAT_BITS-1:0] w;
        logic signed [QUAT_BITS-1:0] z;
        logic signed [QUAT_BITS-1:0] y;
        logic signed [QUAT_BITS-1:0] x;
    } quat_t;

endpackage

// File: rtl/qvr_conj_mul.sv
// First Hamilton product, conj(q) * (v,0): a product stage and a sum stage.
// Depends on qvr_pkg.
module qvr_conj_mul #(
    parameter int VEC_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  qvr_pkg::quat_t                       quat,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [VEC_BITS-1:0]           vec_x,
    input  logic signed [VEC_BITS-1:0]           vec_y,
    input  logic signed [VEC_BITS-1:0]           vec_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [VEC_BITS+16:0]          t_x,
    output logic signed [VEC_BITS+16:0]          t_y,
    output logic signed [VEC_BITS+16:0]          t_z,
    output logic signed [VEC_BITS+16:0]          t_w
);
    import qvr_pkg::*;

    localparam int PW = VEC_BITS + QUAT_BITS;
    localparam int TW = VEC_BITS + 17;

    logic                 prod_valid_reg;
    logic                 prod_ready;
    logic signed [PW-1:0] prod_reg  [12];
    logic signed [PW-1:0] prod_next [12];
    logic                 sum_valid_reg;
    logic signed [TW-1:0] tx_reg, ty_reg, tz_reg, tw_reg;
    logic signed [TW-1:0] tx_next, ty_next, tz_next, tw_next;
    logic                 sum_ready;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    always_comb begin
        // Terms of t_x, t_y, t_z, t_w in groups of three.
        prod_next[0]  = PW'(quat.w) * PW'(vec_x);
        prod_next[1]  = PW'(quat.z) * PW'(vec_y);
        prod_next[2]  = PW'(quat.y) * PW'(vec_z);
        prod_next[3]  = PW'(quat.w) * PW'(vec_y);
        prod_next[4]  = PW'(quat.x) * PW'(vec_z);
        prod_next[5]  = PW'(quat.z) * PW'(vec_x);
        prod_next[6]  = PW'(quat.w) * PW'(vec_z);
        prod_next[7]  = PW'(quat.y) * PW'(vec_x);
        prod_next[8]  = PW'(quat.x) * PW'(vec_y);
        prod_next[9]  = PW'(quat.x) * PW'(vec_x);
        prod_next[10] = PW'(quat.y) * PW'(vec_y);
        prod_next[11] = PW'(quat.z) * PW'(vec_z);
    end

    always_comb begin
        tx_next = TW'(prod_reg[0]) + TW'(prod_reg[1])  - TW'(prod_reg[2]);
        ty_next = TW'(prod_reg[3]) + TW'(prod_reg[4])  - TW'(prod_reg[5]);
        tz_next = TW'(prod_reg[6]) + TW'(prod_reg[7])  - TW'(prod_reg[8]);
        tw_next = TW'(prod_reg[9]) + TW'(prod_reg[10]) + TW'(prod_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) prod_valid_reg <= in_valid;
            if (sum_ready)  sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (sum_ready && prod_valid_reg) begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            tz_reg <= tz_next;
            tw_reg <= tw_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign t_x = tx_reg;
    assign t_y = ty_reg;
    assign t_z = tz_reg;
    assign t_w = tw_reg;

endmodule

// File: rtl/qvr_hamilton.sv
// Second Hamilton product, vector part of t * q, with the rounding bias added.
// Three stages: products, pair sums, final sum. Depends on qvr_pkg.
module qvr_hamilton #(
    parameter int VEC_BITS       = 24,
    parameter int QUAT_FRAC_BITS = 14,
    parameter int SUM_BITS       = 59
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qvr_pkg::quat_t                quat,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VEC_BITS+16:0]   t_x,
    input  logic signed [VEC_BITS+16:0]   t_y,
    input  logic signed [VEC_BITS+16:0]   t_z,
    input  logic signed [VEC_BITS+16:0]   t_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SUM_BITS-1:0]    sum_x,
    output logic signed [SUM_BITS-1:0]    sum_y,
    output logic signed [SUM_BITS-1:0]    sum_z
);
    import qvr_pkg::*;

    localparam int TW = VEC_BITS + 17;
    localparam int PW = TW + QUAT_BITS;
    localparam logic signed [SUM_BITS-1:0] ROUND_BIAS =
        {{(SUM_BITS-1){1'b0}}, 1'b1} << (2*QUAT_FRAC_BITS - 1);

    logic                       prod_valid_reg, pair_valid_reg, sum_valid_reg;
    logic                       prod_ready, pair_ready, sum_ready;
    logic signed [PW-1:0]       prod_reg  [12];
    logic signed [PW-1:0]       prod_next [12];
    logic signed [SUM_BITS-1:0] pair_reg  [6];
    logic signed [SUM_BITS-1:0] pair_next [6];
    logic signed [SUM_BITS-1:0] sx_reg, sy_reg, sz_reg;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign pair_ready = !pair_valid_reg || sum_ready;
    assign prod_ready = !prod_valid_reg || pair_ready;
    assign in_ready   = prod_ready;

    always_comb begin
        // rx = tx*qw + ty*qz - tz*qy + tw*qx
        prod_next[0]  = PW'(t_x) * PW'(quat.w);
        prod_next[1]  = PW'(t_y) * PW'(quat.z);
        prod_next[2]  = PW'(t_z) * PW'(quat.y);
        prod_next[3]  = PW'(t_w) * PW'(quat.x);
        // ry = -tx*qz + ty*qw + tz*qx + tw*qy
        prod_next[4]  = PW'(t_x) * PW'(quat.z);
        prod_next[5]  = PW'(t_y) * PW'(quat.w);
        prod_next[6]  = PW'(t_z) * PW'(quat.x);
        prod_next[7]  = PW'(t_w) * PW'(quat.y);
        // rz = tx*qy - ty*qx + tz*qw + tw*qz
        prod_next[8]  = PW'(t_x) * PW'(quat.y);
        prod_next[9]  = PW'(t_y) * PW'(quat.x);
        prod_next[10] = PW'(t_z) * PW'(quat.w);
        prod_next[11] = PW'(t_w) * PW'(quat.z);
    end

    always_comb begin
        pair_next[0] = SUM_BITS'(prod_reg[0])  + SUM_BITS'(prod_reg[1]);
        pair_next[1] = SUM_BITS'(prod_reg[3])  - SUM_BITS'(prod_reg[2]);
        pair_next[2] = SUM_BITS'(prod_reg[5])  - SUM_BITS'(prod_reg[4]);
        pair_next[3] = SUM_BITS'(prod_reg[6])  + SUM_BITS'(prod_reg[7]);
        pair_next[4] = SUM_BITS'(prod_reg[8])  - SUM_BITS'(prod_reg[9]);
        pair_next[5] = SUM_BITS'(prod_reg[10]) + SUM_BITS'(prod_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) prod_valid_reg <= in_valid;
            if (pair_ready) pair_valid_reg <= prod_valid_reg;
            if (sum_ready)  sum_valid_reg  <= pair_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (pair_ready && prod_valid_reg) begin
            pair_reg <= pair_next;
        end
        if (sum_ready && pair_valid_reg) begin
            sx_reg <= pair_reg[0] + pair_reg[1] + ROUND_BIAS;
            sy_reg <= pair_reg[2] + pair_reg[3] + ROUND_BIAS;
            sz_reg <= pair_reg[4] + pair_reg[5] + ROUND_BIAS;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sum_x = sx_reg;
    assign sum_y = sy_reg;
    assign sum_z = sz_reg;

endmodule

// File: rtl/qvr_round_sat.sv
// Output stage: scales the biased sums back to vector range and saturates.
// Depends on qvr_pkg.
module qvr_round_sat #(
    parameter int VEC_BITS       = 24,
    parameter int QUAT_FRAC_BITS = 14,
    parameter int SUM_BITS       = 59
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SUM_BITS-1:0]    sum_x,
    input  logic signed [SUM_BITS-1:0]    sum_y,
    input  logic signed [SUM_BITS-1:0]    sum_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VEC_BITS-1:0]    rot_x,
    output logic signed [VEC_BITS-1:0]    rot_y,
    output logic signed [VEC_BITS-1:0]    rot_z,
    output logic                          clamped
);
    import qvr_pkg::*;

    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO =
        {{(SUM_BITS-VEC_BITS+1){1'b1}}, {(VEC_BITS-1){1'b0}}};

    logic                       valid_reg;
    logic signed [SUM_BITS-1:0] sh_x, sh_y, sh_z;
    logic signed [VEC_BITS-1:0] rx_next, ry_next, rz_next;
    logic signed [VEC_BITS-1:0] rx_reg, ry_reg, rz_reg;
    logic                       hit_x, hit_y, hit_z;
    logic                       clamped_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sh_x  = sum_x >>> SHIFT;
        sh_y  = sum_y >>> SHIFT;
        sh_z  = sum_z >>> SHIFT;
        hit_x = (sh_x > SAT_HI) || (sh_x < SAT_LO);
        hit_y = (sh_y > SAT_HI) || (sh_y < SAT_LO);
        hit_z = (sh_z > SAT_HI) || (sh_z < SAT_LO);
        rx_next = (sh_x > SAT_HI) ? VEC_BITS'(SAT_HI) :
                  (sh_x < SAT_LO) ? VEC_BITS'(SAT_LO) : VEC_BITS'(sh_x);
        ry_next = (sh_y > SAT_HI) ? VEC_BITS'(SAT_HI) :
                  (sh_y < SAT_LO) ? VEC_BITS'(SAT_LO) : VEC_BITS'(sh_y);
        rz_next = (sh_z > SAT_HI) ? VEC_BITS'(SAT_HI) :
                  (sh_z < SAT_LO) ? VEC_BITS'(SAT_LO) : VEC_BITS'(sh_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            rz_reg      <= rz_next;
            clamped_reg <= hit_x || hit_y || hit_z;
        end
    end

    assign out_valid = valid_reg;
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;
    assign rot_z     = rz_reg;
    assign clamped   = clamped_reg;

endmodule

// File: rtl/quaternion_vector_rotate.sv
// Quaternion vector rotation, top level: configuration registers and pipeline.
// Depends on qvr_pkg, qvr_conj_mul, qvr_hamilton, qvr_round_sat and the defines header.
//
// Rotates one signed 3-D vector per request by the quaternion q held in four
// configuration registers, returning the vector part of conj(q) * (v,0) * q.
// The quaternion components are signed 16-bit fixed point with QUAT_FRAC_BITS
// fraction bits; after reset q is the identity (w = 1.0, x = y = z = 0).
// The first product is kept exact; the second is rounded half up (ties toward
// plus infinity) back to vector scale and saturated to VEC_BITS signed bits,
// with m_tuser set when any coordinate was clamped. q is not normalized,
// so a non-unit quaternion scales the result by its squared norm.
// The block is a six-stage pipeline: the first product (multiply, sum), the
// second product (multiply, pair sums, final sum with rounding bias) and the
// output register (shift and saturate). It accepts one request every cycle
// while s_tready is high, passing each through these stages in order; a stall on the
// result side fills the stages one by one before s_tready drops, and nothing
// is lost or repeated. Write the quaternion only while the pipeline is empty.
`include "quaternion_vector_rotate_defines.svh"

module quaternion_vector_rotate #(
    parameter int VEC_BITS       = 24,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  qvr_pkg::cfg_reg_t                     cfg_addr,
    input  logic [qvr_pkg::QUAT_BITS-1:0]         cfg_wdata,
    // Input requests. s_tdata, lowest bit up: vec_x, vec_y, vec_z, zero pad.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*VEC_BITS+7)/8)*8-1:0]       s_tdata,
    // Results. m_tdata, lowest bit up: rot_x, rot_y, rot_z, zero pad.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((3*VEC_BITS+7)/8)*8-1:0]       m_tdata,
    // m_tuser: clamped.
    output logic                                  m_tuser
);
    import qvr_pkg::*;

    localparam int DATA_BITS = ((3*VEC_BITS+7)/8)*8;
    localparam int PAD_BITS  = DATA_BITS - 3*VEC_BITS;
    localparam int TW        = VEC_BITS + 17;
    // Exact width of the second product sum, with room for the rounding bias.
    localparam int SUM_BITS  = (VEC_BITS + 35 > 2*QUAT_FRAC_BITS + 2) ?
                               VEC_BITS + 35 : 2*QUAT_FRAC_BITS + 2;
    localparam logic [QUAT_BITS-1:0] QUAT_ONE =
        QUAT_BITS'(64'sd1 <<< QUAT_FRAC_BITS);
    localparam logic signed [VEC_BITS-1:0] ROT_MAX = {1'b0, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [VEC_BITS-1:0] ROT_MIN = {1'b1, {(VEC_BITS-1){1'b0}}};

    quat_t quat_reg;

    logic                       cm_valid, cm_ready;
    logic signed [TW-1:0]       t_x, t_y, t_z, t_w;
    logic                       hm_valid, hm_ready;
    logic signed [SUM_BITS-1:0] sum_x, sum_y, sum_z;
    logic signed [VEC_BITS-1:0] rot_x, rot_y, rot_z;
    logic                       clamped;

    // Configuration registers; a write shows on quat_reg in the cycle after cfg_we.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= QUAT_ONE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_QUAT_X: quat_reg.x <= cfg_wdata;
                REG_QUAT_Y: quat_reg.y <= cfg_wdata;
                REG_QUAT_Z: quat_reg.z <= cfg_wdata;
                REG_QUAT_W: quat_reg.w <= cfg_wdata;
            endcase
        end
    end

    qvr_conj_mul #(
        .VEC_BITS (VEC_BITS)
    ) u_conj_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quat      (quat_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vec_x     (s_tdata[VEC_BITS-1:0]),
        .vec_y     (s_tdata[2*VEC_BITS-1:VEC_BITS]),
        .vec_z     (s_tdata[3*VEC_BITS-1:2*VEC_BITS]),
        .out_valid (cm_valid),
        .out_ready (cm_ready),
        .t_x       (t_x),
        .t_y       (t_y),
        .t_z       (t_z),
        .t_w       (t_w)
    );

    qvr_hamilton #(
        .VEC_BITS       (VEC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_hamilton (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quat      (quat_reg),
        .in_valid  (cm_valid),
        .in_ready  (cm_ready),
        .t_x       (t_x),
        .t_y       (t_y),
        .t_z       (t_z),
        .t_w       (t_w),
        .out_valid (hm_valid),
        .out_ready (hm_ready),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .sum_z     (sum_z)
    );

    qvr_round_sat #(
        .VEC_BITS       (VEC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_round_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hm_valid),
        .in_ready  (hm_ready),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .sum_z     (sum_z),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .clamped   (clamped)
    );

    generate
        if (PAD_BITS > 0) begin : g_pad
            assign m_tdata = {{PAD_BITS{1'b0}}, rot_z, rot_y, rot_x};
        end else begin : g_nopad
            assign m_tdata = {rot_z, rot_y, rot_x};
        end
    endgenerate
    assign m_tuser = clamped;

    // The input side only stalls when every stage holds a request and the
    // result side is not taking the oldest one.
    `QVR_ASSERT_IMP(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready,
        "input stalled while the pipeline could still advance")
    // A full pipeline still holds its oldest result in the next cycle.
    `QVR_ASSERT_NEXT(a_full_keeps_result, !s_tready, m_tvalid,
        "result vanished from a full pipeline")
    // A clamped result has at least one coordinate on a rail.
    `QVR_ASSERT_IMP(a_clamp_on_rail, m_tvalid && clamped,
        rot_x == ROT_MAX || rot_x == ROT_MIN || rot_y == ROT_MAX ||
        rot_y == ROT_MIN || rot_z == ROT_MAX || rot_z == ROT_MIN,
        "clamp flag set with no saturated coordinate")
    // The pipeline comes out of reset empty.
    `QVR_ASSERT_IMP(a_reset_empty, !$past(aresetn), !m_tvalid && s_tready,
        "pipeline not empty after reset")

endmodule
